// File: design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and sizing constants for the split-field PML E-x update core.
// ----------------------------------------------------------------------------
package pse_pkg;

    // Depth of the input queue between the front and the back
    localparam int IN_Q_DEPTH  = 4;
    // Depth of the result queue; must cover every transaction in flight
    localparam int OUT_Q_DEPTH = 64;

    // One classified cell update as it waits in the input queue
    typedef struct packed {
        logic [15:0]        cell_id;
        logic               in_store;
        logic signed [31:0] hz_here;
        logic signed [31:0] hz_below_y;
        logic signed [31:0] hy_here;
        logic signed [31:0] hy_below_z;
        logic [30:0]        mesh_y;
        logic [30:0]        mesh_z;
        logic [30:0]        e_fac;
        logic [30:0]        loss;
        logic [30:0]        grade_y;
        logic [30:0]        grade_z;
    } pse_item_t;

    // One result as it waits in the output queue
    typedef struct packed {
        logic [15:0]        cell_id;
        logic signed [31:0] ex;
    } pse_result_t;

    // Status from the back part to the front part
    typedef struct packed {
        logic pop;
        logic clearing;
    } pse_back_status_t;

endpackage

// File: design/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pse_fifo.sv
// ----------------------------------------------------------------------------
// pse_fifo
// Show-ahead FIFO on a registered-read RAM; the RAM read register is the head.
// ----------------------------------------------------------------------------
module pse_fifo #(
    parameter int W     = 32,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output logic         head_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          hv_reg, hv_next;
    logic          re;

    pse_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (push_data),
        .re    (re),
        .raddr (rd_ptr_reg),
        .rdata (head_data)
    );

    // Refill the head register whenever it is empty or being taken
    assign re = (cnt_reg != '0) && (!hv_reg || pop);

    always_comb
    begin
        wr_ptr_next = push ? ((wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = re ? ((rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(re);
        hv_next     = re ? 1'b1 : (pop ? 1'b0 : hv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            hv_reg     <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            hv_reg     <= hv_next;
        end
    end

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = hv_reg;

endmodule

// File: design/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front
// Accepts input transactions, flags cells beyond the store and queues them.
// ----------------------------------------------------------------------------
module pse_front #(
    parameter int PML_CELLS = 65536
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [15:0]                cell_index,
    input  logic signed [31:0]         hz_here,
    input  logic signed [31:0]         hz_below_y,
    input  logic signed [31:0]         hy_here,
    input  logic signed [31:0]         hy_below_z,
    input  logic [30:0]                mesh_factor_y,
    input  logic [30:0]                mesh_factor_z,
    input  logic [30:0]                material_e_factor,
    input  logic [30:0]                material_loss_factor,
    input  logic [30:0]                grade_y,
    input  logic [30:0]                grade_z,
    input  pse_pkg::pse_back_status_t  bst,
    output pse_pkg::pse_item_t         q_item,
    output logic                       q_valid
);

    import pse_pkg::*;

    localparam int IW = $bits(pse_item_t);
    localparam logic [24:0] CELLS = 25'(PML_CELLS);

    pse_item_t     item;
    logic          push;
    logic          full;
    logic [IW-1:0] head;

    // Classify: does the cell have a store entry
    always_comb
    begin
        item.cell_id    = cell_index;
        item.in_store   = ({9'b0, cell_index} < CELLS);
        item.hz_here    = hz_here;
        item.hz_below_y = hz_below_y;
        item.hy_here    = hy_here;
        item.hy_below_z = hy_below_z;
        item.mesh_y     = mesh_factor_y;
        item.mesh_z     = mesh_factor_z;
        item.e_fac      = material_e_factor;
        item.loss       = material_loss_factor;
        item.grade_y    = grade_y;
        item.grade_z    = grade_z;
    end

    // No transaction is taken while the stores are being cleared
    assign in_stall = full || bst.clearing;
    assign push     = in_valid && !in_stall;

    pse_fifo #(.W(IW), .DEPTH(IN_Q_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (item),
        .full       (full),
        .pop        (bst.pop),
        .head_data  (head),
        .head_valid (q_valid)
    );

    assign q_item = pse_item_t'(head);

endmodule

// File: design/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back
// Issues queued cells, runs the split-field arithmetic pipeline with a
// radix-2 divider, writes the stores back and queues the results.
// ----------------------------------------------------------------------------
module pse_back #(
    parameter int PML_CELLS = 65536
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pse_pkg::pse_item_t         q_item,
    input  logic                       q_valid,
    output pse_pkg::pse_back_status_t  bst,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                cell_echo,
    output logic signed [31:0]         ex_value
);

    import pse_pkg::*;

    localparam int DEPTH  = (PML_CELLS > 65536) ? 65536 : PML_CELLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam int DIV_BITS = 32;
    // issue, coefficients, term, numerator, range check, divider, saturate
    localparam int NST = DIV_BITS + 6;
    localparam int RW  = $bits(pse_result_t);
    localparam int OW  = $clog2(OUT_Q_DEPTH + 2);
    localparam logic [46:0] ONE_Q = 47'h10000;
    localparam logic [30:0] R_MAX = 31'h7FFFFFFF;
    localparam logic [31:0] S_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] S_MIN = 32'h80000000;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? S_MIN : S_MAX;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Signed saturation of a quotient magnitude
    function automatic logic [31:0] sat_q(input logic [31:0] q, input logic neg,
                                          input logic ovf);
        logic [31:0] r;
        if (neg)
        begin
            r = (ovf || (q[31] && (q[30:0] != '0))) ? S_MIN : (~q + 1'b1);
        end
        else
        begin
            r = (ovf || q[31]) ? S_MAX : q;
        end
        return r;
    endfunction

    // ---------------- issue control ----------------
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [OW-1:0]     occ_reg, occ_next;
    logic              tag_vld_reg  [1:NST];
    logic              tag_in_reg   [1:NST];
    logic [15:0]       tag_cell_reg [1:NST];
    logic              hazard;
    logic              issue;
    logic              out_pop;

    // Read-after-write hazard against every in-store cell still in flight
    always_comb
    begin
        hazard = 1'b0;
        for (int s = 1; s <= NST; s++)
        begin
            if (tag_vld_reg[s] && tag_in_reg[s] && (tag_cell_reg[s] == q_item.cell_id))
            begin
                hazard = 1'b1;
            end
        end
        hazard = hazard && q_item.in_store;
    end

    assign issue = q_valid && !hazard && !clr_active_reg && (occ_reg < OW'(OUT_Q_DEPTH));
    assign bst.pop      = issue;
    assign bst.clearing = clr_active_reg;

    assign occ_next = occ_reg + OW'(issue) - OW'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            occ_reg        <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (clr_active_reg)
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_active_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
        end
    end

    // Tag line: valid, in-store flag and cell of each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NST; s++)
            begin
                tag_vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            tag_vld_reg[1] <= issue;
            for (int s = 2; s <= NST; s++)
            begin
                tag_vld_reg[s] <= tag_vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_in_reg[1]   <= q_item.in_store;
        tag_cell_reg[1] <= q_item.cell_id;
        for (int s = 2; s <= NST; s++)
        begin
            tag_in_reg[s]   <= tag_in_reg[s-1];
            tag_cell_reg[s] <= tag_cell_reg[s-1];
        end
    end

    // ---------------- split-field stores ----------------
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [31:0]       st_wy, st_wz;
    logic [31:0]       rd_y, rd_z;
    logic [31:0]       fin_y_reg, fin_z_reg;

    assign st_we    = clr_active_reg || (tag_vld_reg[NST] && tag_in_reg[NST]);
    assign st_waddr = clr_active_reg ? clr_addr_reg : tag_cell_reg[NST][ADDR_W-1:0];
    assign st_wy    = clr_active_reg ? '0 : fin_y_reg;
    assign st_wz    = clr_active_reg ? '0 : fin_z_reg;

    pse_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_y (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wy),
        .re    (issue),
        .raddr (q_item.cell_id[ADDR_W-1:0]),
        .rdata (rd_y)
    );

    pse_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_z (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wz),
        .re    (issue),
        .raddr (q_item.cell_id[ADDR_W-1:0]),
        .rdata (rd_z)
    );

    // ---------------- stage 1: captured item, store data arrives ----------------
    pse_item_t s1_item_reg;

    always_ff @(posedge clk)
    begin
        s1_item_reg <= q_item;
    end

    // ---------------- stage 2: differences and coefficient products ----------------
    logic [32:0] dz33, dy33;
    logic [31:0] s2_dhz_reg, s2_dhz_next, s2_dhy_reg, s2_dhy_next;
    logic [61:0] s2_ry_reg, s2_ry_next, s2_rz_reg, s2_rz_next;
    logic [61:0] s2_gy_reg, s2_gy_next, s2_gz_reg, s2_gz_next;
    logic [31:0] s2_oy_reg, s2_oy_next, s2_oz_reg, s2_oz_next;

    always_comb
    begin
        dz33 = {s1_item_reg.hz_here[31], s1_item_reg.hz_here}
             - {s1_item_reg.hz_below_y[31], s1_item_reg.hz_below_y};
        dy33 = {s1_item_reg.hy_here[31], s1_item_reg.hy_here}
             - {s1_item_reg.hy_below_z[31], s1_item_reg.hy_below_z};
        s2_dhz_next = sat33(dz33);
        s2_dhy_next = sat33(dy33);
        s2_ry_next  = 62'(s1_item_reg.mesh_y) * 62'(s1_item_reg.e_fac);
        s2_rz_next  = 62'(s1_item_reg.mesh_z) * 62'(s1_item_reg.e_fac);
        s2_gy_next  = 62'(s1_item_reg.grade_y) * 62'(s1_item_reg.loss);
        s2_gz_next  = 62'(s1_item_reg.grade_z) * 62'(s1_item_reg.loss);
        // cells beyond the store start from zero
        s2_oy_next  = s1_item_reg.in_store ? rd_y : '0;
        s2_oz_next  = s1_item_reg.in_store ? rd_z : '0;
    end

    always_ff @(posedge clk)
    begin
        s2_dhz_reg <= s2_dhz_next;
        s2_dhy_reg <= s2_dhy_next;
        s2_ry_reg  <= s2_ry_next;
        s2_rz_reg  <= s2_rz_next;
        s2_gy_reg  <= s2_gy_next;
        s2_gz_reg  <= s2_gz_next;
        s2_oy_reg  <= s2_oy_next;
        s2_oz_reg  <= s2_oz_next;
    end

    // ---------------- stage 3: update terms and denominators ----------------
    logic [30:0]        ry, rz;
    logic signed [63:0] s3_ty_reg, s3_ty_next, s3_tz_reg, s3_tz_next;
    logic [46:0]        s3_dy_reg, s3_dy_next, s3_dz_reg, s3_dz_next;
    logic [31:0]        s3_oy_reg, s3_oz_reg;

    always_comb
    begin
        ry = (s2_ry_reg[61:47] != '0) ? R_MAX : s2_ry_reg[46:16];
        rz = (s2_rz_reg[61:47] != '0) ? R_MAX : s2_rz_reg[46:16];
        s3_ty_next = $signed({33'b0, ry}) * $signed({{32{s2_dhz_reg[31]}}, s2_dhz_reg});
        s3_tz_next = $signed({33'b0, rz}) * $signed({{32{s2_dhy_reg[31]}}, s2_dhy_reg});
        s3_dy_next = ONE_Q + {1'b0, s2_gy_reg[61:16]};
        s3_dz_next = ONE_Q + {1'b0, s2_gz_reg[61:16]};
    end

    always_ff @(posedge clk)
    begin
        s3_ty_reg <= s3_ty_next;
        s3_tz_reg <= s3_tz_next;
        s3_dy_reg <= s3_dy_next;
        s3_dz_reg <= s3_dz_next;
        s3_oy_reg <= s2_oy_reg;
        s3_oz_reg <= s2_oz_reg;
    end

    // ---------------- stage 4: numerators as sign and magnitude ----------------
    logic signed [63:0] num_y, num_z;
    logic [62:0]        s4_my_reg, s4_my_next, s4_mz_reg, s4_mz_next;
    logic               s4_ny_reg, s4_nz_reg;
    logic [46:0]        s4_dy_reg, s4_dz_reg;

    always_comb
    begin
        num_y = $signed({{16{s3_oy_reg[31]}}, s3_oy_reg, 16'b0}) + s3_ty_reg;
        num_z = $signed({{16{s3_oz_reg[31]}}, s3_oz_reg, 16'b0}) - s3_tz_reg;
        s4_my_next = num_y[63] ? 63'(~num_y + 64'sd1) : num_y[62:0];
        s4_mz_next = num_z[63] ? 63'(~num_z + 64'sd1) : num_z[62:0];
    end

    always_ff @(posedge clk)
    begin
        s4_my_reg <= s4_my_next;
        s4_mz_reg <= s4_mz_next;
        s4_ny_reg <= num_y[63];
        s4_nz_reg <= num_z[63];
        s4_dy_reg <= s3_dy_reg;
        s4_dz_reg <= s3_dz_reg;
    end

    // ---------------- stage 5 and on: range check, then one quotient bit per stage ----------------
    logic [62:0] dv_ry_reg [0:DIV_BITS];
    logic [62:0] dv_rz_reg [0:DIV_BITS];
    logic [31:0] dv_qy_reg [0:DIV_BITS];
    logic [31:0] dv_qz_reg [0:DIV_BITS];
    logic [46:0] dv_dy_reg [0:DIV_BITS];
    logic [46:0] dv_dz_reg [0:DIV_BITS];
    logic        dv_ny_reg [0:DIV_BITS];
    logic        dv_nz_reg [0:DIV_BITS];
    logic        dv_oy_reg [0:DIV_BITS];
    logic        dv_oz_reg [0:DIV_BITS];

    // quotient of 2^32 or more only saturates
    always_ff @(posedge clk)
    begin
        dv_ry_reg[0] <= s4_my_reg;
        dv_rz_reg[0] <= s4_mz_reg;
        dv_qy_reg[0] <= '0;
        dv_qz_reg[0] <= '0;
        dv_dy_reg[0] <= s4_dy_reg;
        dv_dz_reg[0] <= s4_dz_reg;
        dv_ny_reg[0] <= s4_ny_reg;
        dv_nz_reg[0] <= s4_nz_reg;
        dv_oy_reg[0] <= ({16'b0, s4_my_reg[62:32]} >= s4_dy_reg);
        dv_oz_reg[0] <= ({16'b0, s4_mz_reg[62:32]} >= s4_dz_reg);
    end

    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        localparam int K = DIV_BITS - 1 - j;
        logic [78:0] diff_y, diff_z;
        logic        bit_y, bit_z;
        logic [62:0] rem_y_next, rem_z_next;

        // restoring step: subtract the shifted divisor if it fits
        always_comb
        begin
            diff_y     = 79'(dv_ry_reg[j]) - (79'(dv_dy_reg[j]) << K);
            diff_z     = 79'(dv_rz_reg[j]) - (79'(dv_dz_reg[j]) << K);
            bit_y      = !diff_y[78];
            bit_z      = !diff_z[78];
            rem_y_next = bit_y ? diff_y[62:0] : dv_ry_reg[j];
            rem_z_next = bit_z ? diff_z[62:0] : dv_rz_reg[j];
        end

        always_ff @(posedge clk)
        begin
            dv_ry_reg[j+1] <= rem_y_next;
            dv_rz_reg[j+1] <= rem_z_next;
            dv_qy_reg[j+1] <= {dv_qy_reg[j][30:0], bit_y};
            dv_qz_reg[j+1] <= {dv_qz_reg[j][30:0], bit_z};
            dv_dy_reg[j+1] <= dv_dy_reg[j];
            dv_dz_reg[j+1] <= dv_dz_reg[j];
            dv_ny_reg[j+1] <= dv_ny_reg[j];
            dv_nz_reg[j+1] <= dv_nz_reg[j];
            dv_oy_reg[j+1] <= dv_oy_reg[j];
            dv_oz_reg[j+1] <= dv_oz_reg[j];
        end
    end

    // ---------------- last stage: saturated split values ----------------
    logic [31:0] fin_y_next, fin_z_next;

    assign fin_y_next = sat_q(dv_qy_reg[DIV_BITS], dv_ny_reg[DIV_BITS], dv_oy_reg[DIV_BITS]);
    assign fin_z_next = sat_q(dv_qz_reg[DIV_BITS], dv_nz_reg[DIV_BITS], dv_oz_reg[DIV_BITS]);

    always_ff @(posedge clk)
    begin
        fin_y_reg <= fin_y_next;
        fin_z_reg <= fin_z_next;
    end

    // ---------------- result queue ----------------
    pse_result_t   res;
    logic [RW-1:0] res_head;
    pse_result_t   res_out;
    logic          res_full;

    always_comb
    begin
        res.cell_id = tag_cell_reg[NST];
        res.ex      = sat33({fin_y_reg[31], fin_y_reg} + {fin_z_reg[31], fin_z_reg});
    end

    assign out_pop = out_valid && !out_stall;

    pse_fifo #(.W(RW), .DEPTH(OUT_Q_DEPTH)) u_results (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tag_vld_reg[NST] && !res_full),
        .push_data  (res),
        .full       (res_full),
        .pop        (out_pop),
        .head_data  (res_head),
        .head_valid (out_valid)
    );

    assign res_out   = pse_result_t'(res_head);
    assign cell_echo = res_out.cell_id;
    assign ex_value  = res_out.ex;

endmodule

// File: design/pml_split_field_e_update_core.sv
// ----------------------------------------------------------------------------
// pml_split_field_e_update_core
// Split-field PML update of E-x, one boundary cell per transaction.
//
// Input channel (in_valid/in_stall): cell index, four H samples and the
// looked-up mesh, material and grading coefficients. Output channel
// (out_valid/out_stall): the cell index and the new saturated E-x, one
// result per input, in input order.
// Throughput: one transaction per cycle while in_stall is low. A stored
// cell that repeats while its earlier update is in flight waits until
// that update has been written back, since the pipeline from store read
// to store write is 38 stages, 32 of them the radix-2 divider.
// Reset: both split stores are cleared one entry per cycle, over all
// min(PML_CELLS, 65536) entries; in_stall is high throughout.
// Receiver stall: at most 64 results are held in the pipeline and the
// result queue together; after that the 4-entry input queue fills and
// in_stall rises.
// ----------------------------------------------------------------------------
module pml_split_field_e_update_core #(
    parameter int PML_CELLS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        cell_index,
    input  logic signed [31:0] hz_here,
    input  logic signed [31:0] hz_below_y,
    input  logic signed [31:0] hy_here,
    input  logic signed [31:0] hy_below_z,
    input  logic [30:0]        mesh_factor_y,
    input  logic [30:0]        mesh_factor_z,
    input  logic [30:0]        material_e_factor,
    input  logic [30:0]        material_loss_factor,
    input  logic [30:0]        grade_y,
    input  logic [30:0]        grade_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        cell_echo,
    output logic signed [31:0] ex_value
);

    import pse_pkg::*;

    pse_item_t        q_item;
    logic             q_valid;
    pse_back_status_t bst;

    pse_front #(.PML_CELLS(PML_CELLS)) u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .cell_index           (cell_index),
        .hz_here              (hz_here),
        .hz_below_y           (hz_below_y),
        .hy_here              (hy_here),
        .hy_below_z           (hy_below_z),
        .mesh_factor_y        (mesh_factor_y),
        .mesh_factor_z        (mesh_factor_z),
        .material_e_factor    (material_e_factor),
        .material_loss_factor (material_loss_factor),
        .grade_y              (grade_y),
        .grade_z              (grade_z),
        .bst                  (bst),
        .q_item               (q_item),
        .q_valid              (q_valid)
    );

    pse_back #(.PML_CELLS(PML_CELLS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .bst       (bst),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_echo (cell_echo),
        .ex_value  (ex_value)
    );

`ifndef SYNTHESIS
    // nothing is issued while the stores are being cleared
    a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bst.clearing |-> !bst.pop)
        else $error("issue during store clear");

    // the input is held off for the whole clearing pass
    a_stall_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bst.clearing |-> in_stall)
        else $error("input accepted during store clear");

    // the back only takes a queued transaction
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        bst.pop |-> q_valid)
        else $error("pop from empty input queue");
`endif

endmodule

// File: test/tb_pml_split_field_e_update_core.sv
// ----------------------------------------------------------------------------
// tb_pml_split_field_e_update_core
// Self-checking bench for the split-field PML E-x update core. Drives cell
// updates with directed extremes and random traffic (repeated cells, bursty
// sender, stalling receiver) and checks every result, in order, against a
// local fixed-point predictor that keeps its own copy of both split stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pml_split_field_e_update_core;

    localparam int  CELLS       = 65536;
    localparam int  LATENCY     = 42;
    localparam int  DRAIN_WAIT  = 200;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int  N_RANDOM    = 850;

    // One cell update transaction
    typedef struct {
        logic [15:0]        cell_id;
        logic signed [31:0] hz0, hz1, hy0, hy1;
        logic [30:0]        my, mz, ef, lf, gy, gz;
    } cell_upd_t;

    typedef struct {
        logic [15:0]        cell_id;
        logic signed [31:0] ex;
    } ex_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: split-field predictor plus queue of pending E-x results
    // ------------------------------------------------------------------------
    class ex_scoreboard;
        logic signed [31:0] split_y [CELLS];
        logic signed [31:0] split_z [CELLS];
        ex_result_t         pending_ex[$];
        int                 mismatches;

        function new();
            foreach (split_y[i]) begin
                split_y[i] = '0;
                split_z[i] = '0;
            end
            mismatches = 0;
        endfunction

        static function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // New split value: (old*2^16 +/- r*dh) / (2^16 + grade*loss>>16)
        static function logic signed [31:0] split_next(logic signed [31:0] old,
                longint dh, logic [30:0] mesh, logic [30:0] efac,
                logic [30:0] grade, logic [30:0] loss, bit sub);
            longint unsigned r, den, mag, quo;
            longint term, num;
            bit neg;
            r = (longint'(mesh) * longint'(efac)) >> 16;
            if (r > 64'd2147483647) r = 64'd2147483647;
            term = longint'(r) * clip32(dh);
            if (sub) term = -term;
            num = longint'(old) * 65536 + term;
            den = 65536 + ((longint'(grade) * longint'(loss)) >> 16);
            neg = num < 0;
            mag = neg ? -num : num;
            quo = mag / den;
            return 32'(clip32(neg ? -longint'(quo) : longint'(quo)));
        endfunction

        function void note_update(cell_upd_t u);
            logic signed [31:0] ny, nz;
            ex_result_t e;
            ny = split_next(split_y[u.cell_id], longint'(u.hz0) - longint'(u.hz1),
                            u.my, u.ef, u.gy, u.lf, 1'b0);
            nz = split_next(split_z[u.cell_id], longint'(u.hy0) - longint'(u.hy1),
                            u.mz, u.ef, u.gz, u.lf, 1'b1);
            split_y[u.cell_id] = ny;
            split_z[u.cell_id] = nz;
            e.cell_id = u.cell_id;
            e.ex      = 32'(clip32(longint'(ny) + longint'(nz)));
            pending_ex.push_back(e);
        endfunction

        function void check_result(logic [15:0] got_cell, logic signed [31:0] ex);
            ex_result_t e;
            if (pending_ex.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result cell=%0d ex=%0d", got_cell, ex);
                return;
            end
            e = pending_ex.pop_front();
            if (e.cell_id !== got_cell || e.ex !== ex) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("bad result: exp cell=%0d ex=%0d got cell=%0d ex=%0d",
                             e.cell_id, e.ex, got_cell, ex);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        cell_index;
    logic signed [31:0] hz_here, hz_below_y, hy_here, hy_below_z;
    logic [30:0]        mesh_factor_y, mesh_factor_z, material_e_factor;
    logic [30:0]        material_loss_factor, grade_y, grade_z;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        cell_echo;
    logic signed [31:0] ex_value;

    ex_scoreboard sb;
    longint       cycle_count = 0;
    bit           hold_off;
    logic [15:0]  hot_cells[8];

    pml_split_field_e_update_core u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .cell_index           (cell_index),
        .hz_here              (hz_here),
        .hz_below_y           (hz_below_y),
        .hy_here              (hy_here),
        .hy_below_z           (hy_below_z),
        .mesh_factor_y        (mesh_factor_y),
        .mesh_factor_z        (mesh_factor_z),
        .material_e_factor    (material_e_factor),
        .material_loss_factor (material_loss_factor),
        .grade_y              (grade_y),
        .grade_z              (grade_z),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .cell_echo            (cell_echo),
        .ex_value             (ex_value)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pml_split_field_e_update_core: mismatch");
            $finish;
        end
    end

    // Result check on each accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(cell_echo, ex_value);
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_off)
            out_stall <= 1'b1;
        else if (cycle_count[11:10] == 2'd3)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 30);
    end

    function automatic logic [30:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFFFFFF;
            2: return 31'($urandom_range(0, 131072));
            3: return 31'(32'h10000 + $urandom_range(0, 65535));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_h();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 262144)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    function automatic cell_upd_t rand_update();
        cell_upd_t u;
        case ($urandom_range(0, 3))
            0: u.cell_id = hot_cells[$urandom_range(0, 7)];
            1: u.cell_id = 16'($urandom_range(0, 15));
            default: u.cell_id = 16'($urandom);
        endcase
        u.hz0 = rand_h(); u.hz1 = rand_h(); u.hy0 = rand_h(); u.hy1 = rand_h();
        u.my = rand_coef(); u.mz = rand_coef(); u.ef = rand_coef();
        u.lf = rand_coef(); u.gy = rand_coef(); u.gz = rand_coef();
        return u;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_update(cell_upd_t u);
        in_valid             <= 1'b1;
        cell_index           <= u.cell_id;
        hz_here              <= u.hz0;
        hz_below_y           <= u.hz1;
        hy_here              <= u.hy0;
        hy_below_z           <= u.hy1;
        mesh_factor_y        <= u.my;
        mesh_factor_z        <= u.mz;
        material_e_factor    <= u.ef;
        material_loss_factor <= u.lf;
        grade_y              <= u.gy;
        grade_z              <= u.gz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_update(u);
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_ex.size() != 0) @(posedge clk);
    endtask

    // Directed cases: extremes, saturation, same cell back to back, cells at both ends of the store
    task automatic run_directed();
        cell_upd_t u;
        for (int k = 0; k < 20; k++) begin
            u.cell_id = (k < 6) ? 16'd5 : (k[0] ? 16'hFFFF : 16'd0);
            u.hz0 = k[1] ? 32'sh7FFFFFFF : 32'sh80000000;
            u.hz1 = k[1] ? 32'sh80000000 : 32'sh7FFFFFFF;
            u.hy0 = k[2] ? 32'sh80000000 : 32'sh00010000;
            u.hy1 = k[2] ? 32'sh7FFFFFFF : 32'shFFFF0000;
            u.my  = k[3] ? 31'h7FFFFFFF : 31'h10000;
            u.mz  = k[3] ? 31'h7FFFFFFF : 31'h0;
            u.ef  = (k % 5 == 0) ? 31'h0 : 31'h7FFFFFFF;
            u.lf  = (k < 10) ? 31'h0 : 31'h7FFFFFFF;
            u.gy  = k[4] ? 31'h7FFFFFFF : 31'h10000;
            u.gz  = k[0] ? 31'h7FFFFFFF : 31'h0;
            send_update(u);
        end
    endtask

    initial
    begin
        sb          = new();
        hold_off    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cell_index  = '0;
        hz_here = '0; hz_below_y = '0; hy_here = '0; hy_below_z = '0;
        mesh_factor_y = '0; mesh_factor_z = '0; material_e_factor = '0;
        material_loss_factor = '0; grade_y = '0; grade_z = '0;
        foreach (hot_cells[i]) hot_cells[i] = 16'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_drained();

        // Random bursts; one long receiver hold-off fills the core
        for (int n = 0; n < N_RANDOM; ) begin
            int burst;
            if (n == 300) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 600) wait_drained();
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
                send_update(rand_update());
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 12));
        end

        wait_drained();
        repeat (LATENCY + DRAIN_WAIT) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_ex.size() == 0)
            $display("pml_split_field_e_update_core: match");
        else
            $display("pml_split_field_e_update_core: mismatch");
        $finish;
    end

endmodule
